// ===== hdl/trs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trs_pkg
// Shared types and constants of the one-second track resampler.
// ----------------------------------------------------------------------------
package trs_pkg;

   localparam int TIME_W   = 32;   // Q16.16 seconds
   localparam int VAL_W    = 33;   // any point field, sign- or zero-extended
   localparam int DIFF_W   = 34;   // difference of two fields
   localparam int MAG_W    = 33;   // magnitude of a difference
   localparam int Q_W      = 34;   // signed quotient and accumulator
   localparam int GAP_W    = 22;   // saturated gap, Q6.16
   localparam int CNT_W    = 6;    // whole seconds of a gap
   localparam int FRAC_W   = 16;
   localparam int NUM_W    = MAG_W + FRAC_W;
   localparam int STEP_W   = 6;    // divider step counter
   localparam int SEC_W    = 24;
   localparam int FIELDS   = 5;
   localparam int FLD_W    = 3;
   localparam int IN_W     = 136;
   localparam int OUT_W    = 128;

   localparam logic [FLD_W-1:0] FLD_X     = 3'd0;
   localparam logic [FLD_W-1:0] FLD_Y     = 3'd1;
   localparam logic [FLD_W-1:0] FLD_ELEV  = 3'd2;
   localparam logic [FLD_W-1:0] FLD_HR    = 3'd3;
   localparam logic [FLD_W-1:0] FLD_PACE  = 3'd4;

   localparam logic [TIME_W-1:0] ONE_SECOND = 32'h0001_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_EMIT,
      ST_UPDATE,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic             capture;
      logic             anchor_load;
      logic             gap_load;
      logic             div_start;
      logic             div_store;
      logic             emit_step;
      logic             anchor_step;
      logic             final_emit;
      logic [FLD_W-1:0] field;
   } cmd_type;

   typedef struct packed {
      logic anchor_valid;
      logic gap_big;
      logic final_point;
      logic div_done;
      logic emit_last;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// ===== hdl/trs_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module trs_div (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire [trs_pkg::NUM_W-1:0]     num,
   input  wire [trs_pkg::GAP_W-1:0]     den,
   output logic                         done,
   output logic [trs_pkg::NUM_W-1:0]    quo,
   output logic [trs_pkg::GAP_W-1:0]    rem
);
   import trs_pkg::*;

   logic                busy_ff, busy_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [NUM_W-1:0]    rq_ff, rq_in;
   logic [GAP_W-1:0]    rem_ff, rem_in;
   logic                done_ff, done_in;
   logic [GAP_W:0]      trial;
   logic                fits;

   assign trial = {rem_ff, rq_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, den};

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rq_in   = rq_ff;
      rem_in  = rem_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rq_in   = num;
         rem_in  = '0;
      end else if (busy_ff) begin
         rq_in   = {rq_ff[NUM_W-2:0], fits};
         rem_in  = fits ? GAP_W'(trial - {1'b0, den}) : trial[GAP_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rq_ff  <= rq_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quo  = rq_ff;
   assign rem  = rem_ff;

endmodule
`default_nettype wire

// ===== hdl/trs_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trs_ctrl
// Sequencer: gap check, five field divisions, emission loop, final point.
// ----------------------------------------------------------------------------
module trs_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  trs_pkg::status_type   status,
   output trs_pkg::cmd_type      cmd
);
   import trs_pkg::*;

   state_type        state_ff, state_in;
   logic [FLD_W-1:0] field_ff, field_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         field_ff <= '0;
      end else begin
         state_ff <= state_in;
         field_ff <= field_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      field_in   = field_ff;
      cmd        = '0;
      cmd.field  = field_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!status.anchor_valid) begin
               cmd.anchor_load = 1'b1;
               state_in = status.final_point ? ST_FINAL : ST_IDLE;
            end else if (status.gap_big) begin
               cmd.gap_load = 1'b1;
               field_in     = FLD_X;
               state_in     = ST_DIV_START;
            end else begin
               state_in = status.final_point ? ST_FINAL : ST_IDLE;
            end
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               if (field_ff == FLD_PACE) begin
                  state_in = ST_EMIT;
               end else begin
                  field_in = field_ff + 1'b1;
                  state_in = ST_DIV_START;
               end
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_step = 1'b1;
               if (status.emit_last) state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.anchor_step = 1'b1;
            state_in = status.final_point ? ST_FINAL : ST_IDLE;
         end
         ST_FINAL: begin
            if (status.out_free) begin
               cmd.final_emit = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// ===== hdl/trs_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trs_dp
// Anchor, gap, per-field step quotients, accumulators and output register.
// ----------------------------------------------------------------------------
module trs_dp #(
   parameter int MAX_GAP_SECONDS = 63
) (
   input  wire                        clock,
   input  wire                        reset,
   input  trs_pkg::cmd_type           cmd,
   output trs_pkg::status_type        status,
   input  wire [trs_pkg::IN_W-1:0]    req_tdata,
   input  wire                        req_tlast,
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   output logic [trs_pkg::OUT_W-1:0]  rsp_tdata,
   output logic                       rsp_tlast
);
   import trs_pkg::*;

   localparam logic [TIME_W-1:0] CAP = TIME_W'(MAX_GAP_SECONDS) << FRAC_W;

   logic [TIME_W-1:0]              in_time_ff;
   logic signed [VAL_W-1:0]        in_val_ff  [FIELDS];
   logic                           in_fin_ff;
   logic [TIME_W-1:0]              anc_time_ff;
   logic signed [VAL_W-1:0]        anc_val_ff [FIELDS];
   logic                           anc_valid_ff;
   logic [SEC_W-1:0]               sec_ff;
   logic [GAP_W-1:0]               gap_ff;
   logic [CNT_W-1:0]               k_ff;
   logic signed [Q_W-1:0]          step_q_ff  [FIELDS];
   logic [GAP_W-1:0]               step_r_ff  [FIELDS];
   logic signed [Q_W-1:0]          acc_q_ff   [FIELDS];
   logic [GAP_W-1:0]               acc_r_ff   [FIELDS];
   logic                           neg_ff;
   logic                           out_valid_ff;
   logic [OUT_W-1:0]               out_data_ff;
   logic                           out_last_ff;

   logic [TIME_W:0]                gap_full;
   logic [TIME_W-1:0]              gap_sat;
   logic signed [DIFF_W-1:0]       diff;
   logic [MAG_W-1:0]               mag;
   logic                           div_done;
   logic [NUM_W-1:0]               div_quo;
   logic [GAP_W-1:0]               div_rem;
   logic [Q_W-1:0]                 q_mag;
   logic signed [Q_W-1:0]          q_fix;
   logic [GAP_W-1:0]               r_fix;
   logic signed [Q_W-1:0]          cur    [FIELDS];
   logic signed [Q_W-1:0]          q_next [FIELDS];
   logic [GAP_W-1:0]               r_next [FIELDS];
   logic [OUT_W-1:0]               emit_data;
   logic [OUT_W-1:0]               anc_data;
   logic                           out_free;

   assign gap_full = {1'b0, in_time_ff} - {1'b0, anc_time_ff};
   assign gap_sat  = (gap_full[TIME_W-1:0] > CAP) ? CAP : gap_full[TIME_W-1:0];

   assign diff = DIFF_W'(in_val_ff[cmd.field]) - DIFF_W'(anc_val_ff[cmd.field]);
   assign mag  = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

   trs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   ({mag, {FRAC_W{1'b0}}}),
      .den   (gap_ff),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   // floor division: a negative numerator with a remainder rounds one further down
   assign q_mag = div_quo[Q_W-1:0];
   always_comb begin
      q_fix = q_mag;
      r_fix = div_rem;
      if (neg_ff) begin
         if (div_rem == '0) begin
            q_fix = -q_mag;
         end else begin
            q_fix = ~q_mag;
            r_fix = gap_ff - div_rem;
         end
      end
   end

   always_comb begin
      logic [GAP_W:0] r_sum;
      for (int i = 0; i < FIELDS; i++) begin
         cur[i] = Q_W'(anc_val_ff[i]) + acc_q_ff[i];
         r_sum  = {1'b0, acc_r_ff[i]} + {1'b0, step_r_ff[i]};
         if (r_sum >= {1'b0, gap_ff}) begin
            r_next[i] = GAP_W'(r_sum - {1'b0, gap_ff});
            q_next[i] = acc_q_ff[i] + step_q_ff[i] + Q_W'(1);
         end else begin
            r_next[i] = r_sum[GAP_W-1:0];
            q_next[i] = acc_q_ff[i] + step_q_ff[i];
         end
      end
   end

   assign emit_data = {cur[FLD_PACE][15:0], cur[FLD_HR][7:0], cur[FLD_ELEV][15:0],
                       cur[FLD_Y][31:0], cur[FLD_X][31:0], sec_ff};
   assign anc_data  = {anc_val_ff[FLD_PACE][15:0], anc_val_ff[FLD_HR][7:0],
                       anc_val_ff[FLD_ELEV][15:0], anc_val_ff[FLD_Y][31:0],
                       anc_val_ff[FLD_X][31:0], sec_ff};

   assign out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_time_ff          <= req_tdata[31:0];
         in_val_ff[FLD_X]    <= VAL_W'($signed(req_tdata[63:32]));
         in_val_ff[FLD_Y]    <= VAL_W'($signed(req_tdata[95:64]));
         in_val_ff[FLD_ELEV] <= VAL_W'($signed(req_tdata[111:96]));
         in_val_ff[FLD_HR]   <= VAL_W'({1'b0, req_tdata[119:112]});
         in_val_ff[FLD_PACE] <= VAL_W'({1'b0, req_tdata[135:120]});
         in_fin_ff           <= req_tlast;
      end
      if (cmd.gap_load) begin
         gap_ff <= gap_sat[GAP_W-1:0];
         k_ff   <= '0;
         for (int i = 0; i < FIELDS; i++) begin
            acc_q_ff[i] <= '0;
            acc_r_ff[i] <= '0;
         end
      end
      if (cmd.div_start) neg_ff <= diff[DIFF_W-1];
      if (cmd.div_store) begin
         step_q_ff[cmd.field] <= q_fix;
         step_r_ff[cmd.field] <= r_fix;
      end
      if (cmd.emit_step) begin
         k_ff <= k_ff + 1'b1;
         for (int i = 0; i < FIELDS; i++) begin
            acc_q_ff[i] <= q_next[i];
            acc_r_ff[i] <= r_next[i];
         end
      end
      if (cmd.emit_step || cmd.final_emit) begin
         out_data_ff <= cmd.final_emit ? anc_data : emit_data;
         out_last_ff <= cmd.final_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         anc_time_ff  <= '0;
         anc_valid_ff <= 1'b0;
         sec_ff       <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < FIELDS; i++) anc_val_ff[i] <= '0;
      end else begin
         if (cmd.anchor_load) begin
            anc_time_ff  <= in_time_ff;
            anc_valid_ff <= 1'b1;
            for (int i = 0; i < FIELDS; i++) anc_val_ff[i] <= in_val_ff[i];
         end
         if (cmd.anchor_step) begin
            anc_time_ff <= anc_time_ff + {gap_ff[GAP_W-1:FRAC_W], {FRAC_W{1'b0}}};
            for (int i = 0; i < FIELDS; i++) anc_val_ff[i] <= cur[i][VAL_W-1:0];
         end
         if (cmd.emit_step) sec_ff <= sec_ff + 1'b1;
         if (cmd.final_emit) begin
            anc_valid_ff <= 1'b0;
            sec_ff       <= '0;
         end
         if (cmd.emit_step || cmd.final_emit) out_valid_ff <= 1'b1;
         else if (rsp_tready)                 out_valid_ff <= 1'b0;
      end
   end

   assign status.anchor_valid = anc_valid_ff;
   assign status.gap_big      = !gap_full[TIME_W] && (gap_full[TIME_W-1:0] > ONE_SECOND);
   assign status.final_point  = in_fin_ff;
   assign status.div_done     = div_done;
   assign status.emit_last    = (k_ff == gap_ff[GAP_W-1:FRAC_W] - 1'b1);
   assign status.out_free     = out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
`default_nettype wire

// ===== hdl/track_resampler_one_second.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// track_resampler_one_second
// Resamples a time-stamped track to points one second apart.
// ----------------------------------------------------------------------------
// Points enter in time order; points no more than one second after the anchor
// are dropped. A later point opens a segment of floor(gap) seconds (gap capped
// at MAX_GAP_SECONDS) that comes out as linearly interpolated points, one per
// cycle while the sink takes them. Before a segment's first result the five
// fields are divided in turn on one shared bit-serial divider. A final point
// (tlast) is followed by the anchor with rsp_tlast set. One item is worked on
// at a time.
module track_resampler_one_second #(
   parameter int MAX_GAP_SECONDS = 63
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   // sample_time[31:0], pos_x[63:32], pos_y[95:64], elevation[111:96],
   // heart_rate[119:112], pace[135:120]
   input  wire [trs_pkg::IN_W-1:0]    req_tdata,
   input  wire                        req_tlast,     // final_point
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   // second_index[23:0], out_x[55:24], out_y[87:56], out_elevation[103:88],
   // out_heart_rate[111:104], out_pace[127:112]
   output logic [trs_pkg::OUT_W-1:0]  rsp_tdata,
   output logic                       rsp_tlast      // end_of_track
);
   import trs_pkg::*;

   cmd_type    cmd;
   status_type status;

   trs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   trs_dp #(.MAX_GAP_SECONDS(MAX_GAP_SECONDS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// ===== hdl/trs_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trs_checker
// Port-level checks of the resampler, bound to the top level.
// ----------------------------------------------------------------------------
module trs_checker (
   input wire         clock,
   input wire         reset,
   input wire         req_tvalid,
   input wire         req_tready,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [127:0] rsp_tdata,
   input wire         rsp_tlast
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                     && $stable(rsp_tlast))
      else $error("stalled result changed");

   // nothing to show right after reset
   assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // one transaction at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while busy");

   // an offered result carries known data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !$isunknown({rsp_tdata, rsp_tlast}))
      else $error("result data unknown");

endmodule

bind track_resampler_one_second trs_checker u_trs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
